// ===== sv/lottery_runqueue_scheduler_top_defines.svh =====
// Assertion macros for the lottery run-queue scheduler.
// LRS_ASSERT is sampled on clk_i and disabled while rst_ni is low.
// LRS_ASSERT_RST is sampled on clk_i and also checked during reset.
`ifndef LOTTERY_RUNQUEUE_SCHEDULER_TOP_DEFINES_SVH
`define LOTTERY_RUNQUEUE_SCHEDULER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define LRS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define LRS_ASSERT(lbl, prop, msg)
`define LRS_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== sv/lrs_pkg.sv =====
package lrs_pkg;

  // field widths
  localparam int MODE_W   = 2;
  localparam int ID_W     = 8;
  localparam int TICKET_W = 16;
  localparam int RND_W    = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 7;

  // bits needed to count the steps of the remainder loop
  localparam int RND_CNT_W = $clog2(RND_W);

  // stream beat widths, padded to whole bytes
  localparam int S_TDATA_W = ((ID_W + TICKET_W + RND_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((ID_W + OCC_W + 7) / 8) * 8;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_SELECT = 2'd2
  } mode_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  // tickets as weighted in a draw: zero counts as one
  function automatic logic [TICKET_W-1:0] eff_tickets(input logic [TICKET_W-1:0] t);
    logic [TICKET_W-1:0] r;
    r = (t == '0) ? TICKET_W'(1) : t;
    return r;
  endfunction

endpackage

// ===== sv/lottery_runqueue_scheduler_top.sv =====
// Lottery run-queue scheduler: one operation per input beat, one result beat each.
// Add appends at the table tail. Remove scans for the id and moves the last entry into its slot.
// Select: ticket sum pass, 32-step remainder loop, prefix walk and hand-off to the output reg,
// with one entry memory read per cycle in the passes and one draw bit per loop step.
// One operation in flight; a new beat is taken once the result is handed to the output reg.
// Reset (rst_ni low, async) empties the table and drops any pending result; no clearing pass.
`include "lottery_runqueue_scheduler_top_defines.svh"

module lottery_runqueue_scheduler_top #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input beat
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // entry_id [7:0], ticket_count [23:8], random_word [55:24]
  input  logic [lrs_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // mode [1:0]
  input  logic [lrs_pkg::MODE_W-1:0]     s_axis_tuser_i,
  // result beat
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // winner_id [7:0], occupancy [14:8], zero [15]
  output logic [lrs_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  // status [1:0]
  output logic [lrs_pkg::STATUS_W-1:0]   m_axis_tuser_o
);

  import lrs_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int SUM_W = TICKET_W + IDX_W;
  localparam int MEM_W = ID_W + TICKET_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_RM_SCAN,
    S_RM_LAST,
    S_RM_WR,
    S_SUM_SCAN,
    S_DIV,
    S_WALK_SCAN,
    S_DONE
  } state_e;

  state_e                state_q, state_d;
  logic [ID_W-1:0]       id_q, id_d;
  logic [TICKET_W-1:0]   tk_q, tk_d;
  logic [RND_W-1:0]      rnd_q, rnd_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]      issue_q, issue_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]      proc_q, proc_d;
  logic [IDX_W-1:0]      hit_q, hit_d;
  logic [SUM_W-1:0]      total_q, total_d;
  logic [SUM_W-1:0]      rem_q, rem_d;
  logic [SUM_W-1:0]      acc_q, acc_d;
  logic [RND_CNT_W-1:0]  bit_q, bit_d;
  status_e               res_stat_q, res_stat_d;
  logic [ID_W-1:0]       res_win_q, res_win_d;
  logic                  out_vld_q, out_vld_d;
  status_e               out_stat_q, out_stat_d;
  logic [ID_W-1:0]       out_win_q, out_win_d;
  logic [OCC_W-1:0]      out_occ_q, out_occ_d;

  // entry memory: {id, tickets}
  logic [MEM_W-1:0]      mem [MAX_ENTRIES];
  logic [MEM_W-1:0]      rdata_q;
  logic                  mem_we, mem_re;
  logic [IDX_W-1:0]      mem_waddr, mem_raddr;
  logic [MEM_W-1:0]      mem_wdata;

  logic                  s_acc;
  logic                  scan_end;
  logic [ID_W-1:0]       rd_id;
  logic [TICKET_W-1:0]   rd_eff;
  logic [SUM_W:0]        trial;
  logic [SUM_W-1:0]      acc_next;
  logic [CNT_W-1:0]      last_cnt;
  logic [CNT_W+OCC_W-1:0] occ_ext;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  assign rd_id    = rdata_q[MEM_W-1:TICKET_W];
  assign rd_eff   = eff_tickets(rdata_q[TICKET_W-1:0]);
  assign scan_end = !rd_vld_q && (issue_q == cnt_q);
  assign trial    = {rem_q, rnd_q[RND_W-1]};
  assign acc_next = acc_q + SUM_W'(rd_eff);
  assign last_cnt = cnt_q - CNT_W'(1);
  assign occ_ext  = (CNT_W + OCC_W)'(cnt_q);

  // sequencer
  always_comb begin
    state_d    = state_q;
    id_d       = id_q;
    tk_d       = tk_q;
    rnd_d      = rnd_q;
    cnt_d      = cnt_q;
    issue_d    = issue_q;
    rd_vld_d   = 1'b0;
    proc_d     = proc_q;
    hit_d      = hit_q;
    total_d    = total_q;
    rem_d      = rem_q;
    acc_d      = acc_q;
    bit_d      = bit_q;
    res_stat_d = res_stat_q;
    res_win_d  = res_win_q;
    out_vld_d  = out_vld_q;
    out_stat_d = out_stat_q;
    out_win_d  = out_win_q;
    out_occ_d  = out_occ_q;
    mem_we     = 1'b0;
    mem_waddr  = cnt_q[IDX_W-1:0];
    mem_wdata  = {id_q, tk_q};
    mem_re     = 1'b0;
    mem_raddr  = issue_q[IDX_W-1:0];

    // output register drains
    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          id_d       = s_axis_tdata_i[ID_W-1:0];
          tk_d       = s_axis_tdata_i[ID_W+TICKET_W-1:ID_W];
          rnd_d      = s_axis_tdata_i[ID_W+TICKET_W+RND_W-1:ID_W+TICKET_W];
          res_stat_d = STAT_OK;
          res_win_d  = '0;
          issue_d    = '0;
          total_d    = '0;
          acc_d      = '0;
          rem_d      = '0;
          bit_d      = '0;
          case (s_axis_tuser_i)
            MODE_ADD:    state_d = S_ADD;
            MODE_REMOVE: state_d = S_RM_SCAN;
            MODE_SELECT: begin
              if (cnt_q == '0) begin
                res_stat_d = STAT_EMPTY;
                state_d    = S_DONE;
              end else begin
                state_d = S_SUM_SCAN;
              end
            end
            default:     state_d = S_DONE;
          endcase
        end
      end

      S_ADD: begin
        if (cnt_q >= CNT_W'(MAX_ENTRIES)) begin
          res_stat_d = STAT_FULL;
        end else begin
          mem_we = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
        end
        state_d = S_DONE;
      end

      // look for the first slot holding the id
      S_RM_SCAN: begin
        if (rd_vld_q && (rd_id == id_q)) begin
          hit_d   = proc_q;
          state_d = S_RM_LAST;
        end else if (scan_end) begin
          res_stat_d = STAT_NOT_FOUND;
          state_d    = S_DONE;
        end else if (issue_q < cnt_q) begin
          mem_re   = 1'b1;
          proc_d   = issue_q[IDX_W-1:0];
          issue_d  = issue_q + CNT_W'(1);
          rd_vld_d = 1'b1;
        end
      end

      // fetch the last entry, then move it into the hole
      S_RM_LAST: begin
        mem_re    = 1'b1;
        mem_raddr = last_cnt[IDX_W-1:0];
        state_d   = S_RM_WR;
      end

      S_RM_WR: begin
        mem_we    = 1'b1;
        mem_waddr = hit_q;
        mem_wdata = rdata_q;
        cnt_d     = last_cnt;
        state_d   = S_DONE;
      end

      // total of effective tickets
      S_SUM_SCAN: begin
        if (rd_vld_q) begin
          total_d = acc_next + (total_q - acc_q);
        end
        if (scan_end) begin
          state_d = S_DIV;
        end else if (issue_q < cnt_q) begin
          mem_re   = 1'b1;
          proc_d   = issue_q[IDX_W-1:0];
          issue_d  = issue_q + CNT_W'(1);
          rd_vld_d = 1'b1;
        end
      end

      // restoring remainder, one bit of the draw per cycle
      S_DIV: begin
        if (trial >= {1'b0, total_q}) begin
          rem_d = SUM_W'(trial - {1'b0, total_q});
        end else begin
          rem_d = trial[SUM_W-1:0];
        end
        rnd_d = {rnd_q[RND_W-2:0], 1'b0};
        bit_d = bit_q + RND_CNT_W'(1);
        if (bit_q == RND_CNT_W'(RND_W - 1)) begin
          issue_d = '0;
          acc_d   = '0;
          state_d = S_WALK_SCAN;
        end
      end

      // prefix walk: first entry whose range holds the draw
      S_WALK_SCAN: begin
        if (rd_vld_q && (rem_q < acc_next)) begin
          res_win_d = rd_id;
          state_d   = S_DONE;
        end else begin
          if (rd_vld_q) begin
            acc_d = acc_next;
          end
          if (scan_end) begin
            state_d = S_DONE;
          end else if (issue_q < cnt_q) begin
            mem_re   = 1'b1;
            proc_d   = issue_q[IDX_W-1:0];
            issue_d  = issue_q + CNT_W'(1);
            rd_vld_d = 1'b1;
          end
        end
      end

      S_DONE: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d  = 1'b1;
          out_stat_d = res_stat_q;
          out_win_d  = res_win_q;
          out_occ_d  = occ_ext[OCC_W-1:0];
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    id_q       <= id_d;
    tk_q       <= tk_d;
    rnd_q      <= rnd_d;
    issue_q    <= issue_d;
    proc_q     <= proc_d;
    hit_q      <= hit_d;
    total_q    <= total_d;
    rem_q      <= rem_d;
    acc_q      <= acc_d;
    bit_q      <= bit_d;
    res_stat_q <= res_stat_d;
    res_win_q  <= res_win_d;
    out_stat_q <= out_stat_d;
    out_win_q  <= out_win_d;
    out_occ_q  <= out_occ_d;
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_stat_q;
  assign m_axis_tdata_o  = M_TDATA_W'({out_occ_q, out_win_q});

  `LRS_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(MAX_ENTRIES), "entry count beyond table size")
  `LRS_ASSERT(a_cnt_step,
    (cnt_q != $past(cnt_q)) |-> ((cnt_q == $past(cnt_q) + CNT_W'(1)) ||
                                 (cnt_q == $past(cnt_q) - CNT_W'(1))),
    "entry count moved by more than one")
  `LRS_ASSERT(a_rem_below_total, (state_q == S_DIV) |-> (rem_q < total_q),
    "remainder not below ticket total")
  `LRS_ASSERT(a_win_only_ok, (out_vld_q && (out_win_q != '0)) |-> (out_stat_q == STAT_OK),
    "winner id on a failed operation")
  `LRS_ASSERT_RST(a_reset_clear,
    !rst_ni |=> ((cnt_q == '0) && !out_vld_q && (state_q == S_IDLE)),
    "control state not cleared in reset")

endmodule

// ===== test/tb_lottery_runqueue_scheduler_top.sv =====
`timescale 1ns / 1ps

module tb_lottery_runqueue_scheduler_top;
  import lrs_pkg::*;

  localparam int MAX_SLOTS = 64;
  localparam int CYCLE_LIMIT = 1_200_000;
  // tail wait, longer than the longest select
  localparam int TAIL_CYCLES = 2 * MAX_SLOTS + 80;
  localparam int ITEMS_PER_PHASE = 500;
  // mode value with no operation behind it
  localparam logic [MODE_W-1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    status_e      st;
    logic [7:0]   win;
    logic [6:0]   occ;
  } sched_result_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [7:0]        id;
    logic [15:0]       tk;
    logic [31:0]       rnd;
    bit                typed;
    status_e           st;
    logic [7:0]        win;
    logic [6:0]        occ;
  } dir_row_t;

  localparam int DIR_ROWS = 19;
  // directed opening: empty-table errors, field extremes, duplicates, removals
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{MODE_SELECT, 8'h00, 16'h0000, 32'h0000_0000, 1'b1, STAT_EMPTY,     8'h00, 7'd0},
    '{MODE_REMOVE, 8'h55, 16'h0000, 32'h0000_0000, 1'b1, STAT_NOT_FOUND, 8'h00, 7'd0},
    '{OP_SPARE,    8'h00, 16'h0000, 32'h0000_0000, 1'b1, STAT_OK,        8'h00, 7'd0},
    '{MODE_ADD,    8'hFF, 16'hFFFF, 32'h0000_0000, 1'b1, STAT_OK,        8'h00, 7'd1},
    '{MODE_ADD,    8'h00, 16'h0000, 32'hFFFF_FFFF, 1'b1, STAT_OK,        8'h00, 7'd2},
    '{MODE_SELECT, 8'h00, 16'h0000, 32'hFFFF_FFFF, 1'b0, STAT_OK,        8'h00, 7'd0},
    '{MODE_SELECT, 8'h00, 16'h0000, 32'h0000_0000, 1'b0, STAT_OK,        8'h00, 7'd0},
    '{MODE_ADD,    8'hFF, 16'h0001, 32'h0000_0000, 1'b1, STAT_OK,        8'h00, 7'd3},
    '{MODE_SELECT, 8'hFF, 16'hFFFF, 32'h0000_FFFF, 1'b0, STAT_OK,        8'h00, 7'd0},
    '{MODE_REMOVE, 8'hFF, 16'h0000, 32'h0000_0000, 1'b1, STAT_OK,        8'h00, 7'd2},
    '{MODE_SELECT, 8'h00, 16'h0000, 32'h0000_0001, 1'b0, STAT_OK,        8'h00, 7'd0},
    '{MODE_REMOVE, 8'h42, 16'h0000, 32'h0000_0000, 1'b1, STAT_NOT_FOUND, 8'h00, 7'd2},
    '{OP_SPARE,    8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, STAT_OK,        8'h00, 7'd2},
    '{MODE_ADD,    8'h80, 16'h7FFF, 32'h0000_0000, 1'b1, STAT_OK,        8'h00, 7'd3},
    '{MODE_SELECT, 8'h00, 16'h0000, 32'h8000_0000, 1'b0, STAT_OK,        8'h00, 7'd0},
    '{MODE_REMOVE, 8'hFF, 16'h0000, 32'h0000_0000, 1'b1, STAT_OK,        8'h00, 7'd2},
    '{MODE_REMOVE, 8'h00, 16'h0000, 32'h0000_0000, 1'b1, STAT_OK,        8'h00, 7'd1},
    '{MODE_REMOVE, 8'h80, 16'h0000, 32'h0000_0000, 1'b1, STAT_OK,        8'h00, 7'd0},
    '{MODE_SELECT, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, STAT_EMPTY,     8'h00, 7'd0}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [S_TDATA_W-1:0]   s_axis_tdata_i = '0;
  logic [MODE_W-1:0]      s_axis_tuser_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata_o;
  logic [STATUS_W-1:0]    m_axis_tuser_o;

  // mirror of the run queue, updated as each beat is accepted
  logic [7:0]             sched_ids [MAX_SLOTS];
  logic [15:0]            sched_tickets [MAX_SLOTS];
  int                     mirror_len = 0;

  sched_result_t          pending_results [$];
  int                     err_count = 0;
  int                     ops_sent = 0;
  int                     results_seen = 0;
  int                     cycles = 0;
  int                     src_idle_pct = 0;
  int                     sink_stall_pct = 0;

  lottery_runqueue_scheduler_top #(
    .MAX_ENTRIES(MAX_SLOTS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // cycle budget
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // apply one operation to the mirror and return the result it should give
  function automatic sched_result_t lottery_apply(input logic [MODE_W-1:0] mode,
                                                  input logic [7:0] id,
                                                  input logic [15:0] tk,
                                                  input logic [31:0] rnd);
    sched_result_t res;
    int            i;
    int            last;
    bit            found;
    logic [31:0]   total;
    logic [31:0]   draw;
    logic [31:0]   acc;
    logic [31:0]   weight;
    res = '{STAT_OK, 8'h00, 7'd0};
    found = 1'b0;
    case (mode)
      MODE_ADD: begin
        if (mirror_len >= MAX_SLOTS) begin
          res.st = STAT_FULL;
        end else begin
          sched_ids[mirror_len] = id;
          sched_tickets[mirror_len] = tk;
          mirror_len++;
        end
      end
      MODE_REMOVE: begin
        res.st = STAT_NOT_FOUND;
        // lowest slot holding the id gets the last entry
        for (i = 0; i < mirror_len && !found; i++) begin
          if (sched_ids[i] == id) begin
            last = mirror_len - 1;
            sched_ids[i] = sched_ids[last];
            sched_tickets[i] = sched_tickets[last];
            mirror_len = last;
            res.st = STAT_OK;
            found = 1'b1;
          end
        end
      end
      MODE_SELECT: begin
        if (mirror_len == 0) begin
          res.st = STAT_EMPTY;
        end else begin
          total = '0;
          for (i = 0; i < mirror_len; i++)
            total += (sched_tickets[i] == 16'h0) ? 32'd1 : {16'h0, sched_tickets[i]};
          draw = rnd % total;
          acc = '0;
          for (i = 0; i < mirror_len && !found; i++) begin
            weight = (sched_tickets[i] == 16'h0) ? 32'd1 : {16'h0, sched_tickets[i]};
            if (draw < acc + weight) begin
              res.win = sched_ids[i];
              found = 1'b1;
            end
            acc += weight;
          end
        end
      end
      default: begin
      end
    endcase
    res.occ = 7'(mirror_len);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch on result %0d, %s: got %0d, expected %0d",
             results_seen, what, got, want);
    err_count++;
  endtask

  // drive one input beat and log its expected result once accepted
  task automatic send_op(input logic [MODE_W-1:0] mode, input logic [7:0] id,
                         input logic [15:0] tk, input logic [31:0] rnd,
                         input bit typed, input sched_result_t typed_res);
    sched_result_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {rnd, tk, id};
    s_axis_tuser_i <= mode;
    do @(posedge clk_i); while (!s_axis_tready_o);
    res = lottery_apply(mode, id, tk, rnd);
    pending_results.push_back(typed ? typed_res : res);
    if (mode != OP_SPARE) ops_sent++;
  endtask

  task automatic check_result();
    sched_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("beat with nothing pending, status", m_axis_tuser_o, 0);
    end else begin
      want = pending_results.pop_front();
      if (m_axis_tuser_o !== want.st)
        report_mismatch("status", m_axis_tuser_o, want.st);
      if (m_axis_tdata_o[7:0] !== want.win)
        report_mismatch("winner_id", m_axis_tdata_o[7:0], want.win);
      if (m_axis_tdata_o[14:8] !== want.occ)
        report_mismatch("occupancy", m_axis_tdata_o[14:8], want.occ);
    end
    results_seen++;
  endtask

  // result side: check accepted beats, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      check_result();
    end
    m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  // random field helpers
  function automatic logic [15:0] pick_tickets();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'hFFFF;
      3, 4: return 16'($urandom_range(1, 16));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(19))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // small id pool now and then so duplicates show up
  function automatic logic [7:0] pick_add_id();
    if ($urandom_range(99) < 30) return 8'($urandom_range(7));
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_present_id();
    if (mirror_len == 0) return 8'($urandom);
    return sched_ids[$urandom_range(mirror_len - 1)];
  endfunction

  task automatic rand_op(input logic [MODE_W-1:0] mode, input logic [7:0] id);
    send_op(mode, id, pick_tickets(), pick_word(), 1'b0, '0);
  endtask

  // grow to a full table, then push a few adds past full
  task automatic run_fill();
    int extra;
    extra = $urandom_range(1, 3);
    while (extra > 0) begin
      if (mirror_len > 0 && $urandom_range(99) < 25) begin
        rand_op(MODE_SELECT, 8'($urandom));
      end else begin
        if (mirror_len >= MAX_SLOTS) extra--;
        rand_op(MODE_ADD, pick_add_id());
      end
    end
  endtask

  // shrink to empty, then hit the empty-table cases
  task automatic run_drain();
    int r;
    while (mirror_len > 0) begin
      r = $urandom_range(99);
      if (r < 60) rand_op(MODE_REMOVE, pick_present_id());
      else if (r < 72) rand_op(MODE_REMOVE, 8'($urandom));
      else if (r < 95) rand_op(MODE_SELECT, 8'($urandom));
      else rand_op(OP_SPARE, 8'($urandom));
    end
    rand_op(MODE_SELECT, 8'($urandom));
    rand_op(MODE_REMOVE, 8'($urandom));
  endtask

  // short mixed stretch, noise included
  task automatic run_mix();
    int n;
    int r;
    n = $urandom_range(20, 40);
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 35) rand_op(MODE_ADD, pick_add_id());
      else if (r < 55) rand_op(MODE_REMOVE, pick_present_id());
      else if (r < 65) rand_op(MODE_REMOVE, 8'($urandom));
      else if (r < 95) rand_op(MODE_SELECT, 8'($urandom));
      else rand_op(OP_SPARE, 8'($urandom));
    end
  endtask

  // main sequence
  initial begin
    int k;
    int phase;
    int r;
    sched_result_t typed_res;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (k = 0; k < DIR_ROWS; k++) begin
      typed_res = '{DIR_TABLE[k].st, DIR_TABLE[k].win, DIR_TABLE[k].occ};
      send_op(DIR_TABLE[k].mode, DIR_TABLE[k].id, DIR_TABLE[k].tk, DIR_TABLE[k].rnd,
              DIR_TABLE[k].typed, typed_res);
    end

    // random part in idling phases: none, source idle, sink stall, both
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 76; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 76; end
        default: begin src_idle_pct = 27; sink_stall_pct = 27; end
      endcase
      run_fill();
      while (ops_sent < DIR_ROWS + (phase + 1) * ITEMS_PER_PHASE) begin
        r = $urandom_range(99);
        if (r < 30) run_fill();
        else if (r < 55) run_drain();
        else run_mix();
      end
    end
    s_axis_tvalid_i <= 1'b0;

    // drain outstanding results, then watch for strays
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (err_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/lrs_pkg.sv
sv/lottery_runqueue_scheduler_top.sv
test/tb_lottery_runqueue_scheduler_top.sv
